// File: rtl/nu2x_pkg.sv
`default_nettype none
package nu2x_pkg;

  // fixed field widths
  localparam int PIX_W      = 24;
  localparam int FW_W       = 13;
  localparam int FH_W       = 15;
  localparam int ROW_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  // line buffer depth default and frame height limit
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int HEIGHT_LIMIT  = 16384;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // input item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage
`default_nettype wire

// File: rtl/nearest_upscale_2x.sv
// 2x nearest-neighbour upscaler, two ping-pong line buffers in block memory.
// An accepted item's stored column is registered into the read stage, then into the output stage.
// Throughput is set by the single output pixel port (four results per item); a new item
// is taken while the last one's results go out, result-free items every cycle while s1 is not held.
// Reset (synchronous, rst_n low) sets both frame sizes to one and clears counters,
// bank, drain flag and the pipeline valids; line buffer contents are not cleared.
`default_nettype none
module nearest_upscale_2x #(
  parameter int MAX_WIDTH = nu2x_pkg::MAX_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration
  input  wire                               cfg_we,
  input  wire  [nu2x_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [nu2x_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_cmd,
  input  wire  [nu2x_pkg::PIX_W-1:0]        in_pixel,
  // result items
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [nu2x_pkg::PIX_W-1:0]        out_pixel,
  output logic                              out_last_of_run,
  output logic                              out_end_of_frame
);
  import nu2x_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);
  localparam logic [15:0] HLIM16 = 16'(HEIGHT_LIMIT);

  // configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(1);
      frame_height_r <= FH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective last column and last row, clamped to the legal range
  logic [15:0]      fw16, fh16, wm1_16, hm1_16;
  logic [AW-1:0]    wm1;
  logic [ROW_W-1:0] hm1;

  always_comb begin
    fw16 = 16'(frame_width_r);
    fh16 = 16'(frame_height_r);
    if (fw16 == 16'd0)        wm1_16 = 16'd0;
    else if (fw16 > MAXW16)   wm1_16 = MAXW16 - 16'd1;
    else                      wm1_16 = fw16 - 16'd1;
    if (fh16 == 16'd0)        hm1_16 = 16'd0;
    else if (fh16 > HLIM16)   hm1_16 = HLIM16 - 16'd1;
    else                      hm1_16 = fh16 - 16'd1;
    wm1 = wm1_16[AW-1:0];
    hm1 = hm1_16[ROW_W-1:0];
  end

  // frame position state
  logic [AW-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             write_bank_r, write_bank_nxt;
  logic [AW-1:0]    drain_col_r, drain_col_nxt;
  logic             drain_pending_r, drain_pending_nxt;

  // read stage (memory data arrives) and output stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_bank_r, s1_bank_nxt;
  logic             s1_eof_r, s1_eof_nxt;
  logic             s1_move;
  logic             out_valid_r;
  logic [1:0]       out_cnt_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_eof_r;

  // memory access controls
  logic             accept;
  logic             rd_en;
  logic [AW-1:0]    mem_addr;
  logic             wr_a, wr_b;
  logic [PIX_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]    col_in, col_dr;
  logic             last_in_col, last_drain_col;

  // read stage hands over once the output block is free or its last result leaves unstalled
  assign s1_move  = s1_valid_r && (!out_valid_r || (out_cnt_r == 2'd3 && !out_stall));
  assign in_stall = s1_valid_r && !s1_move;
  assign accept   = in_valid && !in_stall;

  assign col_in         = (in_col_r > wm1) ? wm1 : in_col_r;
  assign col_dr         = (drain_col_r > wm1) ? wm1 : drain_col_r;
  assign last_in_col    = (in_col_r >= wm1);
  assign last_drain_col = (drain_col_r >= wm1);

  // item decode and state update
  always_comb begin
    in_col_nxt        = in_col_r;
    in_row_nxt        = in_row_r;
    write_bank_nxt    = write_bank_r;
    drain_col_nxt     = drain_col_r;
    drain_pending_nxt = drain_pending_r;
    s1_valid_nxt      = s1_valid_r && !s1_move;
    s1_bank_nxt       = s1_bank_r;
    s1_eof_nxt        = s1_eof_r;
    rd_en             = 1'b0;
    mem_addr          = col_in;
    wr_a              = 1'b0;
    wr_b              = 1'b0;
    if (accept) begin
      priority if (in_cmd == CMD_DRAIN) begin
        mem_addr = col_dr;
        if (drain_pending_r) begin
          rd_en        = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_bank_nxt  = write_bank_r;
          s1_eof_nxt   = last_drain_col;
          if (last_drain_col) begin
            drain_pending_nxt = 1'b0;
            drain_col_nxt     = '0;
            in_col_nxt        = '0;
            in_row_nxt        = '0;
          end else begin
            drain_col_nxt = drain_col_r + AW'(1);
          end
        end
      end else if (!drain_pending_r) begin
        // pixel: store in write bank, emit from the completed row
        if (in_row_r != '0) begin
          rd_en        = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_bank_nxt  = write_bank_r;
          s1_eof_nxt   = 1'b0;
        end
        wr_a = !write_bank_r;
        wr_b = write_bank_r;
        if (last_in_col) begin
          in_col_nxt     = '0;
          write_bank_nxt = !write_bank_r;
          if (in_row_r >= hm1) begin
            drain_pending_nxt = 1'b1;
            drain_col_nxt     = '0;
          end else begin
            in_row_nxt = in_row_r + ROW_W'(1);
          end
        end else begin
          in_col_nxt = in_col_r + AW'(1);
        end
      end else begin
        // pixel while a drain is pending: dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r        <= '0;
      in_row_r        <= '0;
      write_bank_r    <= 1'b0;
      drain_col_r     <= '0;
      drain_pending_r <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      in_col_r        <= in_col_nxt;
      in_row_r        <= in_row_nxt;
      write_bank_r    <= write_bank_nxt;
      drain_col_r     <= drain_col_nxt;
      drain_pending_r <= drain_pending_nxt;
      s1_valid_r      <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_bank_r <= s1_bank_nxt;
    s1_eof_r  <= s1_eof_nxt;
  end

  // line buffers, one write and one registered read per cycle each
  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_a) line_a[mem_addr] <= in_pixel;
    if (rd_en) rd_a_r <= line_a[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) line_b[mem_addr] <= in_pixel;
    if (rd_en) rd_b_r <= line_b[mem_addr];
  end

  // output block: four results per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_cnt_r   <= 2'd0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
      out_cnt_r   <= 2'd0;
    end else if (out_valid_r && !out_stall) begin
      if (out_cnt_r == 2'd3) out_valid_r <= 1'b0;
      out_cnt_r <= out_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r <= s1_bank_r ? rd_a_r : rd_b_r;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pix_r;
  assign out_last_of_run  = (out_cnt_r == 2'd3);
  assign out_end_of_frame = out_eof_r && (out_cnt_r == 2'd3);

endmodule
`default_nettype wire

// File: tb/nearest_upscale_2x_tb.sv
module nearest_upscale_2x_tb;
  import nu2x_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pix;
  } feed_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             eof;
  } up_pixel_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_PIXEL;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_last_of_run;
  logic                  out_end_of_frame;

  nearest_upscale_2x dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel        (out_pixel),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  // items waiting to be offered, and output pixels still owed
  feed_item_t feed_q[$];
  up_pixel_t  upscaled_q[$];

  // shadow of the scaler: registers, line banks and frame position
  logic [FW_W-1:0]  cfg_w;
  logic [FH_W-1:0]  cfg_h;
  logic [PIX_W-1:0] row_a [MAX_W];
  logic [PIX_W-1:0] row_b [MAX_W];
  logic [11:0]      col_at;
  logic [ROW_W-1:0] row_at;
  logic             wr_bank;
  logic [11:0]      flush_col;
  logic             flush_due;

  int   errors = 0;
  int   items_sent = 0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;
  logic squeeze_arm = 1'b0;
  logic squeezed = 1'b0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // four copies of one source pixel, last flagged, end of frame on request
  task automatic emit_quad(input logic [PIX_W-1:0] px, input logic eof);
    int k;
    for (k = 0; k < 4; k++)
      upscaled_q.push_back('{pix: px, last: (k == 3), eof: (k == 3) && eof});
  endtask

  task automatic upscale_item(input logic cmd, input logic [PIX_W-1:0] px);
    int w, h, col;
    logic [PIX_W-1:0] held;
    logic done;
    w = (cfg_w == 0) ? 1 : (int'(cfg_w) > MAX_W) ? MAX_W : int'(cfg_w);
    h = (cfg_h == 0) ? 1 : (int'(cfg_h) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(cfg_h);
    if (cmd == CMD_DRAIN) begin
      // flush one column of the final row; ignored unless a flush is due
      if (flush_due) begin
        col = (int'(flush_col) >= w) ? w - 1 : int'(flush_col);
        held = wr_bank ? row_a[col] : row_b[col];
        done = (int'(flush_col) >= w - 1);
        emit_quad(held, done);
        if (done) begin
          flush_due = 1'b0;
          flush_col = '0;
          col_at = '0;
          row_at = '0;
        end else begin
          flush_col = flush_col + 12'd1;
        end
      end
    end else if (!flush_due) begin
      // store the pixel, replay the same column of the previous row
      col = (int'(col_at) >= w) ? w - 1 : int'(col_at);
      if (row_at != 0) begin
        held = wr_bank ? row_a[col] : row_b[col];
        emit_quad(held, 1'b0);
      end
      if (wr_bank) row_b[col] = px;
      else row_a[col] = px;
      if (int'(col_at) >= w - 1) begin
        col_at = '0;
        wr_bank = ~wr_bank;
        if (int'(row_at) >= h - 1) begin
          flush_due = 1'b1;
          flush_col = '0;
        end else begin
          row_at = row_at + ROW_W'(1);
        end
      end else begin
        col_at = col_at + 12'd1;
      end
    end
  endtask

  // predictor and checker, all on the rising edge
  always @(posedge clk) begin
    up_pixel_t got, want;
    in_fire = 1'b0;
    if (!rst_n) begin
      cfg_w = FW_W'(1);
      cfg_h = FH_W'(1);
      col_at = '0;
      row_at = '0;
      wr_bank = 1'b0;
      flush_col = '0;
      flush_due = 1'b0;
      upscaled_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) cfg_w = cfg_wdata[FW_W-1:0];
        else if (cfg_index == CFG_FRAME_HEIGHT) cfg_h = cfg_wdata[FH_W-1:0];
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        upscale_item(in_cmd, in_pixel);
        void'(feed_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        got = {out_pixel, out_last_of_run, out_end_of_frame};
        if (upscaled_q.size() == 0) begin
          $display("%0t: unexpected pixel %06h last %0b eof %0b",
                   $time, got.pix, got.last, got.eof);
          errors++;
        end else begin
          want = upscaled_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected pixel %06h last %0b eof %0b, got %06h last %0b eof %0b",
                     $time, want.pix, want.last, want.eof, got.pix, got.last, got.eof);
            errors++;
          end
        end
      end
    end
  end

  // sender: holds a stalled item, otherwise offers the next one or idles
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // keep the stalled item as it is
    end else if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
      in_valid <= 1'b1;
      in_cmd   <= feed_q[0].cmd;
      in_pixel <= feed_q[0].pix;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (squeeze_arm && !squeezed) begin
      squeezed = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  task automatic push_item(input logic cmd, input logic [PIX_W-1:0] px);
    feed_q.push_back('{cmd: cmd, pix: px});
  endtask

  // wait for every item to go in and every owed pixel to come out
  task automatic wait_quiet();
    int guard;
    guard = 0;
    while ((feed_q.size() != 0 || in_valid || upscaled_q.size() != 0) && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  // both registers, back to back; called at a falling edge with the block idle
  task automatic set_frame(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one well-formed frame of random pixels and its flush, with stray items
  // that the block must ignore (flush ticks mid-frame, pixels while flushing)
  task automatic queue_frame(input int w, input int h);
    int r, c;
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++) begin
        if ($urandom_range(99) < 8) push_item(CMD_DRAIN, PIX_W'($urandom()));
        push_item(CMD_PIXEL, PIX_W'($urandom()));
        items_sent++;
      end
    for (c = 0; c < w; c++) begin
      if ($urandom_range(99) < 8) push_item(CMD_PIXEL, PIX_W'($urandom()));
      push_item(CMD_DRAIN, PIX_W'($urandom()));
      items_sent++;
    end
  endtask

  // after a ragged stretch, feed single items until a new frame would start
  task automatic finish_frame();
    while (flush_due || col_at != 0 || row_at != 0) begin
      push_item(flush_due ? CMD_DRAIN : CMD_PIXEL, PIX_W'($urandom()));
      wait_quiet();
    end
  endtask

  initial begin
    int w_reg, h_reg, n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes, one pixel frame
    push_item(CMD_PIXEL, 24'h3C3C3C);
    push_item(CMD_DRAIN, 24'h000000);
    wait_quiet();

    // 3x3 frame with extreme pixel values and every stray case
    set_frame(3, 3);
    push_item(CMD_DRAIN, 24'hFFFFFF);
    push_item(CMD_PIXEL, 24'h000000);
    push_item(CMD_PIXEL, 24'hFFFFFF);
    push_item(CMD_PIXEL, 24'h0000FF);
    push_item(CMD_DRAIN, 24'h000000);
    push_item(CMD_PIXEL, 24'hFF0000);
    push_item(CMD_PIXEL, 24'h00FF00);
    push_item(CMD_PIXEL, 24'h123456);
    push_item(CMD_PIXEL, 24'hA5A5A5);
    push_item(CMD_PIXEL, 24'h5A5A5A);
    push_item(CMD_PIXEL, 24'hFEDCBA);
    push_item(CMD_PIXEL, 24'h777777);
    push_item(CMD_DRAIN, 24'h000000);
    push_item(CMD_DRAIN, 24'hFFFFFF);
    push_item(CMD_DRAIN, 24'h000000);
    push_item(CMD_DRAIN, 24'h000000);
    wait_quiet();

    // zero sizes behave as one
    set_frame(0, 0);
    push_item(CMD_PIXEL, 24'hFFFFFF);
    push_item(CMD_DRAIN, 24'h000000);
    wait_quiet();

    // width just above the buffer depth: a short start of row 0, then the
    // width drops so that the row ends and the frame completes
    set_frame(MAX_W + 1, 2);
    repeat (10) push_item(CMD_PIXEL, PIX_W'($urandom()));
    wait_quiet();
    set_frame(3, 2);
    finish_frame();

    // height just above the limit, one pixel wide, a few rows in
    set_frame(1, HEIGHT_LIMIT + 1);
    repeat (3) push_item(CMD_PIXEL, PIX_W'($urandom()));
    wait_quiet();
    set_frame(1, 1);
    finish_frame();

    // a full frame with no idling on either side
    calm = 1'b1;
    set_frame(16, 4);
    queue_frame(16, 4);
    wait_quiet();
    calm = 1'b0;

    // random sizes and content; the first round runs into a long receiver hold
    items_sent = 0;
    squeeze_arm = 1'b1;
    while (items_sent < 300) begin
      n = $urandom_range(99);
      w_reg = (n < 5) ? 0 : (n < 12) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      n = $urandom_range(99);
      h_reg = (n < 5) ? 0 : (n < 12) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      set_frame(w_reg, h_reg);
      repeat ($urandom_range(1, 3)) queue_frame((w_reg == 0) ? 1 : w_reg,
                                                (h_reg == 0) ? 1 : h_reg);
      // now and then a ragged stretch of arbitrary items
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(5, 25))
          push_item(($urandom_range(3) == 0) ? CMD_DRAIN : CMD_PIXEL, PIX_W'($urandom()));
      end
      wait_quiet();
      finish_frame();
    end

    wait_quiet();
    if (upscaled_q.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived, next %06h",
               $time, upscaled_q.size(), upscaled_q[0].pix);
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #24000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/nu2x_pkg.sv
rtl/nearest_upscale_2x.sv
tb/nearest_upscale_2x_tb.sv
